@@ hdl/lsbc_pkg.sv @@
// ----------------------------------------------------------------------------
// lsbc_pkg
// Shared types and constants of the line sensor blob centroid detector.
// ----------------------------------------------------------------------------
`default_nettype none

package lsbc_pkg;

   // Build defaults
   localparam int PIXELS_DEFAULT = 128;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // Field widths
   localparam int PIXEL_W = 8;
   localparam int LIMIT_W = 7;
   localparam int CNT_W = 8;
   localparam int SUM_W = CNT_W + LIMIT_W;
   localparam int CENTROID_W = 15;
   localparam int CREDIT_W = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 8;

   // Centroid divider: dividend is the position sum scaled by 256
   localparam int FRAC_W = 8;
   localparam int DIVIDEND_W = SUM_W + FRAC_W;
   localparam int DIV_STEPS = DIVIDEND_W;
   localparam int STEP_W = $clog2(DIV_STEPS);

   localparam logic [CNT_W-1:0] HIT_SAT = {CNT_W{1'b1}};
   localparam logic [CREDIT_W-1:0] MISS_CREDIT_RESET = 3'd3;

   // Register reset values
   localparam logic [PIXEL_W-1:0] THRESHOLD_RESET = 8'd106;
   localparam logic [LIMIT_W-1:0] LEFT_LIMIT_RESET = 7'd13;
   localparam logic [LIMIT_W-1:0] RIGHT_LIMIT_RESET = 7'd115;
   localparam logic [LIMIT_W-1:0] WINDOW_FIRST_RESET = 7'd10;
   localparam logic [LIMIT_W-1:0] WINDOW_LAST_RESET = 7'd117;
   localparam logic [CNT_W-1:0] MIN_HITS_RESET = 8'd1;
   localparam logic [CNT_W-1:0] MAX_HITS_RESET = 8'd15;
   localparam logic [CREDIT_W-1:0] MISS_REPEATS_RESET = 3'd3;

   // Register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_THRESHOLD    = 3'd0,
      CSR_LEFT_LIMIT   = 3'd1,
      CSR_RIGHT_LIMIT  = 3'd2,
      CSR_WINDOW_FIRST = 3'd3,
      CSR_WINDOW_LAST  = 3'd4,
      CSR_MIN_HITS     = 3'd5,
      CSR_MAX_HITS     = 3'd6,
      CSR_MISS_REPEATS = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [PIXEL_W-1:0]  threshold;
      logic [LIMIT_W-1:0]  left_limit;
      logic [LIMIT_W-1:0]  right_limit;
      logic [LIMIT_W-1:0]  window_first;
      logic [LIMIT_W-1:0]  window_last;
      logic [CNT_W-1:0]    min_hits;
      logic [CNT_W-1:0]    max_hits;
      logic [CREDIT_W-1:0] miss_repeats;
   } cfg_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               last_pixel;
   } req_type;

   typedef struct packed {
      logic                  obstacle_found;
      logic [CENTROID_W-1:0] centroid_q8;
      logic [CNT_W-1:0]      hits_in_frame;
   } rsp_type;

   // Per-frame totals handed from front to back
   typedef struct packed {
      logic [CNT_W-1:0] hits;
      logic [SUM_W-1:0] sum;
   } frame_type;

endpackage : lsbc_pkg

`default_nettype wire

@@ hdl/lsbc_front.sv @@
// ----------------------------------------------------------------------------
// lsbc_front
// Pixel front end: tracks the pixel index, classifies hits and accumulates
// the hit count and position sum; pushes the totals at each frame end.
// ----------------------------------------------------------------------------
`default_nettype none

module lsbc_front
   import lsbc_pkg::*;
#(
   parameter int PIXELS = PIXELS_DEFAULT
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire cfg_type   cfg,
   input  wire logic      req_valid,
   output logic           req_ready,
   input  wire req_type   req_item,
   input  wire logic      queue_full,
   output logic           push,
   output frame_type      push_frame
);

   localparam int IDX_W = $clog2(PIXELS);
   localparam int CMP_W = (IDX_W > LIMIT_W) ? IDX_W : LIMIT_W;
   localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(PIXELS - 1);

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] hits_ff, hits_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic             accept;
   logic             in_window;
   logic             hit;
   logic [CMP_W-1:0] idx_wide;
   logic [CNT_W-1:0] hits_acc;
   logic [SUM_W-1:0] sum_acc;

   // Take a pixel whenever the queue can still hold a frame
   assign req_ready = !queue_full;
   assign accept = req_valid && req_ready;

   // Classify the pixel
   assign idx_wide = CMP_W'(idx_ff);
   assign in_window = (idx_wide >= CMP_W'(cfg.window_first)) &&
                      (idx_wide <= CMP_W'(cfg.window_last));
   assign hit = in_window && (req_item.pixel > cfg.threshold) && (hits_ff != HIT_SAT);

   // Accumulate; hits only occur at indexes inside the 7-bit window
   assign hits_acc = hit ? hits_ff + CNT_W'(1) : hits_ff;
   assign sum_acc = hit ? sum_ff + SUM_W'(idx_wide) : sum_ff;

   assign push = accept && req_item.last_pixel;
   assign push_frame = '{hits: hits_acc, sum: sum_acc};

   // Next frame state: clear at frame end, saturate the index
   always_comb begin
      idx_in = idx_ff;
      hits_in = hits_ff;
      sum_in = sum_ff;
      if (accept) begin
         if (req_item.last_pixel) begin
            idx_in = '0;
            hits_in = '0;
            sum_in = '0;
         end else begin
            hits_in = hits_acc;
            sum_in = sum_acc;
            if (idx_ff != IDX_MAX) begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         hits_ff <= '0;
         sum_ff <= '0;
      end else begin
         idx_ff <= idx_in;
         hits_ff <= hits_in;
         sum_ff <= sum_in;
      end
   end

endmodule : lsbc_front

`default_nettype wire

@@ hdl/lsbc_queue.sv @@
// ----------------------------------------------------------------------------
// lsbc_queue
// Short first-in first-out queue of frame totals between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module lsbc_queue
   import lsbc_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire frame_type push_frame,
   input  wire logic      pop,
   output frame_type      head_frame,
   output logic           full,
   output logic           empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(DEPTH);

   frame_type          slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full = (count_ff == COUNT_FULL);
   assign empty = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign head_frame = slot_ff[rd_ptr_ff];

   // Advance pointers with wrap, track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Store the pushed frame
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_frame;
      end
   end

endmodule : lsbc_queue

`default_nettype wire

@@ hdl/lsbc_back.sv @@
// ----------------------------------------------------------------------------
// lsbc_back
// Frame back end: tests the detection limits, divides out the Q.8 centroid
// bit by bit, manages the miss credit and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lsbc_back
   import lsbc_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire cfg_type   cfg,
   input  wire logic      queue_empty,
   input  wire frame_type head_frame,
   output logic           pop,
   output logic           rsp_valid,
   input  wire logic      rsp_ready,
   output rsp_type        rsp_item
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   state_type              state_ff;
   frame_type              frame_ff;
   logic [CREDIT_W-1:0]    credit_ff;
   logic [DIVIDEND_W-1:0]  quot_ff;
   logic [CNT_W-1:0]       rem_ff;
   logic [STEP_W-1:0]      step_ff;
   rsp_type                result_ff;
   logic                   rsp_valid_ff;
   rsp_type                rsp_item_ff;

   logic [SUM_W-1:0]       left_prod;
   logic [SUM_W-1:0]       right_prod;
   logic                   found;
   logic [CNT_W:0]         rem_shift;
   logic                   rem_ge;
   logic                   out_free;
   logic                   load_out;

   assign pop = (state_ff == ST_IDLE) && !queue_empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_item_ff;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign load_out = (state_ff == ST_EMIT) && out_free;

   // Limits tested exactly as sum against limit times count
   assign left_prod = SUM_W'(cfg.left_limit) * SUM_W'(frame_ff.hits);
   assign right_prod = SUM_W'(cfg.right_limit) * SUM_W'(frame_ff.hits);
   assign found = (frame_ff.hits > cfg.min_hits) && (frame_ff.hits < cfg.max_hits) &&
                  (frame_ff.sum > left_prod) && (frame_ff.sum < right_prod);

   // One restoring division step
   assign rem_shift = {rem_ff, quot_ff[DIVIDEND_W-1]};
   assign rem_ge = (rem_shift >= {1'b0, frame_ff.hits});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         credit_ff <= MISS_CREDIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Raise valid on a new result, drop it once taken
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (!queue_empty) begin
                  frame_ff <= head_frame;
                  state_ff <= ST_DECIDE;
               end
            end
            ST_DECIDE: begin
               if (found) begin
                  credit_ff <= cfg.miss_repeats;
                  quot_ff <= {frame_ff.sum, {FRAC_W{1'b0}}};
                  rem_ff <= '0;
                  step_ff <= '0;
                  state_ff <= ST_DIVIDE;
               end else if (credit_ff != '0) begin
                  credit_ff <= credit_ff - CREDIT_W'(1);
                  result_ff <= '{obstacle_found: 1'b0, centroid_q8: '0,
                                 hits_in_frame: frame_ff.hits};
                  state_ff <= ST_EMIT;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_DIVIDE: begin
               rem_ff <= rem_ge ? CNT_W'(rem_shift - {1'b0, frame_ff.hits})
                                : rem_shift[CNT_W-1:0];
               quot_ff <= {quot_ff[DIVIDEND_W-2:0], rem_ge};
               step_ff <= step_ff + STEP_W'(1);
               if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
                  result_ff <= '{obstacle_found: 1'b1,
                                 centroid_q8: {quot_ff[CENTROID_W-2:0], rem_ge},
                                 hits_in_frame: frame_ff.hits};
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               // Load the output register when it is free or being emptied
               if (load_out) begin
                  rsp_item_ff <= result_ff;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule : lsbc_back

`default_nettype wire

@@ hdl/line_sensor_blob_centroid_detect.sv @@
// ----------------------------------------------------------------------------
// line_sensor_blob_centroid_detect
// Thresholded one-dimensional centroid detector for a linear image sensor.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock on the req_ channel, with last_pixel
// closing each frame. Pixels inside the index window and above threshold
// are counted and their indexes summed; at frame end the totals go into a
// four-frame queue and the front keeps taking pixels at one per cycle. The
// back end tests the hit and position limits, then divides out the Q.8
// centroid with a restoring divider, one quotient bit per cycle. A frame
// without a detection gives a not-found report, or none when no report is
// due. A finished result waits in the back end while the output register
// still holds one that has not been taken. The front stalls (req_ready
// low) only while the queue holds four unprocessed frames. Each result
// waits in an output register while the back end works on the next frame.
// Registers are written through csr_ only while the block is idle; the
// user must keep to this, as the block itself has no check for it.
// ----------------------------------------------------------------------------
`default_nettype none

module line_sensor_blob_centroid_detect
   import lsbc_pkg::*;
#(
   parameter int PIXELS = PIXELS_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire req_type                req_item,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output rsp_type                     rsp_item,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type   cfg_ff;
   logic      queue_full;
   logic      queue_empty;
   logic      push;
   logic      pop;
   frame_type push_frame;
   frame_type head_frame;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold <= THRESHOLD_RESET;
         cfg_ff.left_limit <= LEFT_LIMIT_RESET;
         cfg_ff.right_limit <= RIGHT_LIMIT_RESET;
         cfg_ff.window_first <= WINDOW_FIRST_RESET;
         cfg_ff.window_last <= WINDOW_LAST_RESET;
         cfg_ff.min_hits <= MIN_HITS_RESET;
         cfg_ff.max_hits <= MAX_HITS_RESET;
         cfg_ff.miss_repeats <= MISS_REPEATS_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_THRESHOLD:    cfg_ff.threshold <= csr_wdata;
            CSR_LEFT_LIMIT:   cfg_ff.left_limit <= csr_wdata[LIMIT_W-1:0];
            CSR_RIGHT_LIMIT:  cfg_ff.right_limit <= csr_wdata[LIMIT_W-1:0];
            CSR_WINDOW_FIRST: cfg_ff.window_first <= csr_wdata[LIMIT_W-1:0];
            CSR_WINDOW_LAST:  cfg_ff.window_last <= csr_wdata[LIMIT_W-1:0];
            CSR_MIN_HITS:     cfg_ff.min_hits <= csr_wdata;
            CSR_MAX_HITS:     cfg_ff.max_hits <= csr_wdata;
            CSR_MISS_REPEATS: cfg_ff.miss_repeats <= csr_wdata[CREDIT_W-1:0];
            default:          cfg_ff <= cfg_ff;
         endcase
      end
   end

   lsbc_front #(
      .PIXELS(PIXELS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .queue_full (queue_full),
      .push       (push),
      .push_frame (push_frame)
   );

   lsbc_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_frame (push_frame),
      .pop        (pop),
      .head_frame (head_frame),
      .full       (queue_full),
      .empty      (queue_empty)
   );

   lsbc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .queue_empty (queue_empty),
      .head_frame  (head_frame),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_item    (rsp_item)
   );

endmodule : line_sensor_blob_centroid_detect

`default_nettype wire

@@ hdl/lsbc_checker.sv @@
// ----------------------------------------------------------------------------
// lsbc_checker
// Port-level checks of the centroid detector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lsbc_checker
   import lsbc_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_item
);

   localparam logic [CENTROID_W-1:0] CENTROID_TOP = 15'd32512;

   // Hold a stalled result
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("result changed or dropped while stalled");

   // Not-found reports carry no centroid
   a_miss_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.obstacle_found |-> rsp_item.centroid_q8 == '0)
      else $error("not-found report with nonzero centroid");

   // A detection has hits and a centroid inside the 7-bit index range
   a_found_sane : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.obstacle_found |->
         rsp_item.hits_in_frame != '0 && rsp_item.centroid_q8 <= CENTROID_TOP)
      else $error("detection with no hits or centroid out of range");

   // Come out of reset with no result pending
   a_reset_quiet : assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule : lsbc_checker

bind line_sensor_blob_centroid_detect lsbc_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_item  (rsp_item)
);

`default_nettype wire
